### src/otg_pkg.sv
// ----------------------------------------------------------------------------
// otg_pkg
// Shared types and constants for the multi-level over-temperature guard.
// ----------------------------------------------------------------------------
package otg_pkg;

    typedef enum logic [1:0] {
        LVL_NORMAL = 2'd0,
        LVL_WARN   = 2'd1,
        LVL_DERATE = 2'd2,
        LVL_STOP   = 2'd3
    } t_level;

    typedef struct packed {
        logic [15:0] warn_threshold;
        logic [15:0] derate_threshold;
        logic [15:0] stop_threshold;
        logic [15:0] recover_threshold;
        logic [15:0] confirm_ms;
    } t_cfg;

    typedef struct packed {
        t_level      internal_level;
        t_level      reported_level;
        logic [31:0] time_base;
    } t_chan_state;

    // Input beat layout, highest field first
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] now_ms;
        logic [15:0] temperature;
        logic [3:0]  channel;
    } t_sample;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 3'd4;

    localparam logic [15:0] WARN_RESET    = 16'd85;
    localparam logic [15:0] DERATE_RESET  = 16'd95;
    localparam logic [15:0] STOP_RESET    = 16'd105;
    localparam logic [15:0] RECOVER_RESET = 16'd75;
    localparam logic [15:0] CONFIRM_RESET = 16'd5000;

    // Valid samples lie strictly between these limits
    localparam logic signed [16:0] TEMP_MAX_LIMIT = 17'sd1000;
    localparam logic signed [16:0] TEMP_MIN_LIMIT = -17'sd50;

endpackage

### src/otg_cfg_regs.sv
// ----------------------------------------------------------------------------
// otg_cfg_regs
// Threshold and confirm-time registers behind a plain write port.
// ----------------------------------------------------------------------------
module otg_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [otg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_wdata,
    output otg_pkg::t_cfg                 o_cfg
);

    otg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_threshold    <= otg_pkg::WARN_RESET;
            r_cfg.derate_threshold  <= otg_pkg::DERATE_RESET;
            r_cfg.stop_threshold    <= otg_pkg::STOP_RESET;
            r_cfg.recover_threshold <= otg_pkg::RECOVER_RESET;
            r_cfg.confirm_ms        <= otg_pkg::CONFIRM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                otg_pkg::CFG_WARN:    r_cfg.warn_threshold    <= i_cfg_wdata;
                otg_pkg::CFG_DERATE:  r_cfg.derate_threshold  <= i_cfg_wdata;
                otg_pkg::CFG_STOP:    r_cfg.stop_threshold    <= i_cfg_wdata;
                otg_pkg::CFG_RECOVER: r_cfg.recover_threshold <= i_cfg_wdata;
                otg_pkg::CFG_CONFIRM: r_cfg.confirm_ms        <= i_cfg_wdata;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/otg_level_logic.sv
// ----------------------------------------------------------------------------
// otg_level_logic
// Per-sample decision: range check, hold timing and level transitions.
// ----------------------------------------------------------------------------
module otg_level_logic (
    input  logic                 i_chan_ok,
    input  logic [15:0]          i_temperature,
    input  logic [31:0]          i_now_ms,
    input  otg_pkg::t_cfg        i_cfg,
    input  otg_pkg::t_chan_state i_state,
    output otg_pkg::t_chan_state o_state,
    output logic                 o_state_we,
    output otg_pkg::t_level      o_level,
    output logic                 o_rejected
);

    logic signed [16:0] t_ext;
    logic signed [16:0] warn_ext;
    logic signed [16:0] derate_ext;
    logic signed [16:0] stop_ext;
    logic signed [16:0] recov_ext;
    logic               range_bad;
    logic               went_back;
    logic [31:0]        base;
    logic [31:0]        elapsed;
    logic               held;
    logic               above_warn;
    logic               above_derate;
    logic               above_stop;
    logic               at_recover;
    otg_pkg::t_chan_state nxt;

    always_comb begin
        t_ext      = {i_temperature[15], i_temperature};
        warn_ext   = {1'b0, i_cfg.warn_threshold};
        derate_ext = {1'b0, i_cfg.derate_threshold};
        stop_ext   = {1'b0, i_cfg.stop_threshold};
        recov_ext  = {1'b0, i_cfg.recover_threshold};

        range_bad  = (t_ext >= otg_pkg::TEMP_MAX_LIMIT) || (t_ext <= otg_pkg::TEMP_MIN_LIMIT);

        // Timestamp went backwards: restart the time base at now
        went_back  = i_now_ms < i_state.time_base;
        base       = went_back ? i_now_ms : i_state.time_base;
        elapsed    = i_now_ms - base;
        held       = elapsed > {16'd0, i_cfg.confirm_ms};

        above_warn   = t_ext > warn_ext;
        above_derate = t_ext > derate_ext;
        above_stop   = t_ext > stop_ext;
        at_recover   = t_ext <= recov_ext;

        nxt           = i_state;
        nxt.time_base = base;

        unique case (i_state.internal_level)
            otg_pkg::LVL_NORMAL: begin
                if (above_warn) begin
                    nxt.internal_level = otg_pkg::LVL_WARN;
                end
                nxt.reported_level = otg_pkg::LVL_NORMAL;
                nxt.time_base      = i_now_ms;
            end
            otg_pkg::LVL_WARN: begin
                priority if (above_derate) begin
                    nxt.internal_level = otg_pkg::LVL_DERATE;
                    nxt.time_base      = i_now_ms;
                end else if (above_warn) begin
                    if (held) begin
                        nxt.reported_level = otg_pkg::LVL_WARN;
                        nxt.time_base      = i_now_ms;
                    end
                end else if (at_recover) begin
                    if (held) begin
                        nxt.internal_level = otg_pkg::LVL_NORMAL;
                        nxt.reported_level = otg_pkg::LVL_NORMAL;
                        nxt.time_base      = i_now_ms;
                    end
                end else begin
                    // hysteresis band: hold
                end
            end
            otg_pkg::LVL_DERATE: begin
                priority if (above_stop) begin
                    nxt.internal_level = otg_pkg::LVL_STOP;
                    nxt.time_base      = i_now_ms;
                end else if (above_derate) begin
                    if (held) begin
                        nxt.reported_level = otg_pkg::LVL_DERATE;
                        nxt.time_base      = i_now_ms;
                    end
                end else if (!above_warn) begin
                    if (held) begin
                        nxt.internal_level = otg_pkg::LVL_WARN;
                        nxt.reported_level = otg_pkg::LVL_WARN;
                        nxt.time_base      = i_now_ms;
                    end
                end else begin
                    // between warn and derate: hold
                end
            end
            otg_pkg::LVL_STOP: begin
                priority if (above_stop) begin
                    if (held) begin
                        nxt.reported_level = otg_pkg::LVL_STOP;
                        nxt.time_base      = i_now_ms;
                    end
                end else if (!above_derate) begin
                    if (held) begin
                        nxt.internal_level = otg_pkg::LVL_DERATE;
                        nxt.reported_level = otg_pkg::LVL_DERATE;
                        nxt.time_base      = i_now_ms;
                    end
                end else begin
                    // between derate and stop: hold
                end
            end
            default: ;
        endcase

        o_state    = nxt;
        o_state_we = i_chan_ok && !range_bad;
        o_rejected = !o_state_we;
        o_level    = o_state_we ? nxt.reported_level : otg_pkg::LVL_STOP;
    end

endmodule

### src/multi_level_overtemp_guard.sv
// ----------------------------------------------------------------------------
// multi_level_overtemp_guard
// Four-level over-temperature protection with per-channel hold timing.
//
//   port group   dir  fields (lowest bit first)
//   s_axis       in   tdata: channel[3:0], temperature[19:4], now_ms[51:20]
//   m_axis       out  tdata: level[1:0]; tuser: rejected
//   cfg          in   write enable, register index, 16-bit data
//
// One sample per cycle sustained while m_axis is not stalled; a sample passes
// through the input register, then the result register. The per-channel
// state update is a read-modify-write between the two registers.
// Reset is synchronous, active low, and returns all channels to normal.
// A stall on m_axis holds both registers; s_axis keeps taking a beat while
// the input register is empty or moving on.
// ----------------------------------------------------------------------------
module multi_level_overtemp_guard #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // channel, temperature, now_ms, zero pad
    input  logic [55:0]                   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // level, zero pad
    output logic [7:0]                    o_m_axis_tdata,
    // rejected
    output logic                          o_m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic [otg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_wdata
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    otg_pkg::t_cfg        cfg;
    otg_pkg::t_sample     r_in;
    logic                 r_in_valid;
    logic                 r_out_valid;
    otg_pkg::t_level      r_out_level;
    logic                 r_out_rejected;
    otg_pkg::t_chan_state r_state [NUM_CHANNELS];

    logic                 out_free;
    logic                 advance;
    logic                 chan_ok;
    logic [CH_W-1:0]      ch_idx;
    otg_pkg::t_chan_state cur_state;
    otg_pkg::t_chan_state nxt_state;
    logic                 state_we;
    otg_pkg::t_level      res_level;
    logic                 res_rejected;

    otg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    assign chan_ok = r_in.channel < 4'(NUM_CHANNELS);
    assign ch_idx  = r_in.channel[CH_W-1:0];

    always_comb begin
        cur_state = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (ch_idx == CH_W'(i)) begin
                cur_state = r_state[i];
            end
        end
    end

    otg_level_logic u_logic (
        .i_chan_ok     (chan_ok),
        .i_temperature (r_in.temperature),
        .i_now_ms      (r_in.now_ms),
        .i_cfg         (cfg),
        .i_state       (cur_state),
        .o_state       (nxt_state),
        .o_state_we    (state_we),
        .o_level       (res_level),
        .o_rejected    (res_rejected)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= otg_pkg::t_sample'(i_s_axis_tdata);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_level    <= res_level;
            r_out_rejected <= res_rejected;
        end
    end

    // Channel state: commit an accepted sample's state as it moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_state[i] <= '{internal_level: otg_pkg::LVL_NORMAL,
                                reported_level: otg_pkg::LVL_NORMAL,
                                time_base:      32'd0};
            end
        end else if (advance && state_we) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (ch_idx == CH_W'(i)) begin
                    r_state[i] <= nxt_state;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_level};
    assign o_m_axis_tuser  = r_out_rejected;

endmodule

### tb/otg_result_checker.sv
// ----------------------------------------------------------------------------
// otg_result_checker
// Watches the sample, result and register-write channels of the guard,
// predicts the level of every accepted sample from its own per-channel
// copy of the protection state, and compares each result beat in order.
// ----------------------------------------------------------------------------
module otg_result_checker #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [55:0]                   i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [7:0]                    i_m_tdata,
    input  logic                          i_m_tuser,
    input  logic                          i_cfg_we,
    input  logic [otg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        otg_pkg::t_level level;
        logic            rejected;
    } t_verdict;

    otg_pkg::t_cfg   guard_cfg;
    otg_pkg::t_level level_now [NUM_CHANNELS];
    otg_pkg::t_level level_shown [NUM_CHANNELS];
    logic [31:0]     hold_start [NUM_CHANNELS];

    t_verdict    level_queue [$];
    int          fail_count = 0;
    int          pending_n = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    task automatic report_mismatch(input string what);
        $display("ERROR %0t ns: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_guard();
        guard_cfg.warn_threshold    = otg_pkg::WARN_RESET;
        guard_cfg.derate_threshold  = otg_pkg::DERATE_RESET;
        guard_cfg.stop_threshold    = otg_pkg::STOP_RESET;
        guard_cfg.recover_threshold = otg_pkg::RECOVER_RESET;
        guard_cfg.confirm_ms        = otg_pkg::CONFIRM_RESET;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            level_now[i]   = otg_pkg::LVL_NORMAL;
            level_shown[i] = otg_pkg::LVL_NORMAL;
            hold_start[i]  = '0;
        end
    endtask

    task automatic write_guard_reg(input logic [otg_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [15:0] val);
        case (idx)
            otg_pkg::CFG_WARN:    guard_cfg.warn_threshold    = val;
            otg_pkg::CFG_DERATE:  guard_cfg.derate_threshold  = val;
            otg_pkg::CFG_STOP:    guard_cfg.stop_threshold    = val;
            otg_pkg::CFG_RECOVER: guard_cfg.recover_threshold = val;
            otg_pkg::CFG_CONFIRM: guard_cfg.confirm_ms        = val;
            default: ;
        endcase
    endtask

    // Advance one channel's protection machine and return its reported level, or STOP and rejected for a bad sample
    function automatic t_verdict guard_level(input otg_pkg::t_sample beat);
        t_verdict    res;
        int          temp, warn, derate, stop, recov, ch;
        logic [31:0] now, elapsed;
        logic        held;

        temp   = int'($signed(beat.temperature));
        now    = beat.now_ms;
        res.level    = otg_pkg::LVL_STOP;
        res.rejected = 1'b1;
        if (temp >= int'(otg_pkg::TEMP_MAX_LIMIT) || temp <= int'(otg_pkg::TEMP_MIN_LIMIT) ||
            int'(beat.channel) >= NUM_CHANNELS)
            return res;

        ch     = int'(beat.channel);
        warn   = int'(guard_cfg.warn_threshold);
        derate = int'(guard_cfg.derate_threshold);
        stop   = int'(guard_cfg.stop_threshold);
        recov  = int'(guard_cfg.recover_threshold);

        // Restart the hold timer when the clock steps back
        if (now < hold_start[ch])
            hold_start[ch] = now;
        elapsed = now - hold_start[ch];
        held    = elapsed > {16'd0, guard_cfg.confirm_ms};

        case (level_now[ch])
            otg_pkg::LVL_NORMAL: begin
                if (temp > warn)
                    level_now[ch] = otg_pkg::LVL_WARN;
                level_shown[ch] = otg_pkg::LVL_NORMAL;
                hold_start[ch]  = now;
            end
            otg_pkg::LVL_WARN: begin
                if (temp > derate) begin
                    level_now[ch]  = otg_pkg::LVL_DERATE;
                    hold_start[ch] = now;
                end else if (temp > warn) begin
                    if (held) begin
                        level_shown[ch] = otg_pkg::LVL_WARN;
                        hold_start[ch]  = now;
                    end
                end else if (temp <= recov) begin
                    if (held) begin
                        level_now[ch]   = otg_pkg::LVL_NORMAL;
                        level_shown[ch] = otg_pkg::LVL_NORMAL;
                        hold_start[ch]  = now;
                    end
                end
            end
            otg_pkg::LVL_DERATE: begin
                if (temp > stop) begin
                    level_now[ch]  = otg_pkg::LVL_STOP;
                    hold_start[ch] = now;
                end else if (temp > derate) begin
                    if (held) begin
                        level_shown[ch] = otg_pkg::LVL_DERATE;
                        hold_start[ch]  = now;
                    end
                end else if (temp <= warn) begin
                    if (held) begin
                        level_now[ch]   = otg_pkg::LVL_WARN;
                        level_shown[ch] = otg_pkg::LVL_WARN;
                        hold_start[ch]  = now;
                    end
                end
            end
            default: begin
                if (temp > stop) begin
                    if (held) begin
                        level_shown[ch] = otg_pkg::LVL_STOP;
                        hold_start[ch]  = now;
                    end
                end else if (temp <= derate) begin
                    if (held) begin
                        level_now[ch]   = otg_pkg::LVL_DERATE;
                        level_shown[ch] = otg_pkg::LVL_DERATE;
                        hold_start[ch]  = now;
                    end
                end
            end
        endcase

        res.level    = level_shown[ch];
        res.rejected = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            clear_guard();
            level_queue.delete();
        end else begin
            if (i_cfg_we)
                write_guard_reg(i_cfg_idx, i_cfg_wdata);
            if (i_s_tvalid && i_s_tready)
                level_queue.push_back(guard_level(otg_pkg::t_sample'(i_s_tdata)));
            if (i_m_tvalid && i_m_tready) begin
                if (level_queue.size() == 0) begin
                    report_mismatch($sformatf("result beat with no sample waiting: tdata=%h",
                                              i_m_tdata));
                end else begin
                    want = level_queue.pop_front();
                    if (i_m_tdata[1:0] !== want.level)
                        report_mismatch($sformatf("level %0d, predicted %0d",
                                                  i_m_tdata[1:0], want.level));
                    if (i_m_tdata[7:2] !== 6'd0)
                        report_mismatch($sformatf("tdata padding %h not zero", i_m_tdata[7:2]));
                    if (i_m_tuser !== want.rejected)
                        report_mismatch($sformatf("rejected flag %b, predicted %b",
                                                  i_m_tuser, want.rejected));
                end
            end
        end
        pending_n <= level_queue.size();
    end

endmodule

### tb/tb_multi_level_overtemp_guard.sv
// ----------------------------------------------------------------------------
// tb_multi_level_overtemp_guard
// Drives samples into the over-temperature guard: a directed walk through
// every level, stale and wrapping timestamps and rejected samples, then
// random phases under several register settings with random stalls on
// both streams outside one steady phase. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_multi_level_overtemp_guard;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS   = 2;
    localparam int PHASE_SAMPLES  = 270;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CFG_REG_COUNT  = 5;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [55:0]                   s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [7:0]                    m_tdata;
    logic                          m_tuser;
    logic                          cfg_we = 1'b0;
    logic [otg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [15:0]                   cfg_wdata = '0;

    int                   fail_count;
    int                   pending;
    logic                 steady_flow = 1'b0;
    otg_pkg::t_cfg        cur_cfg;
    logic [31:0]          clock_track [16];

    multi_level_overtemp_guard #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata)
    );

    otg_result_checker #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady_flow || ($urandom_range(0, 99) >= 11);
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_sample(input int ch, input int temp, input logic [31:0] now);
        otg_pkg::t_sample beat;
        beat.pad         = '0;
        beat.now_ms      = now;
        beat.temperature = 16'(temp);
        beat.channel     = 4'(ch);
        while (!steady_flow && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold the sample stream until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input otg_pkg::t_cfg setting);
        logic [15:0] vals [CFG_REG_COUNT];
        vals[otg_pkg::CFG_WARN]    = setting.warn_threshold;
        vals[otg_pkg::CFG_DERATE]  = setting.derate_threshold;
        vals[otg_pkg::CFG_STOP]    = setting.stop_threshold;
        vals[otg_pkg::CFG_RECOVER] = setting.recover_threshold;
        vals[otg_pkg::CFG_CONFIRM] = setting.confirm_ms;
        cfg_we <= 1'b1;
        for (int i = 0; i < CFG_REG_COUNT; i++) begin
            cfg_idx   <= otg_pkg::CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        // Unmapped indexes must leave the registers alone
        for (int i = CFG_REG_COUNT; i < (1 << otg_pkg::CFG_IDX_W); i++) begin
            cfg_idx   <= otg_pkg::CFG_IDX_W'(i);
            cfg_wdata <= 16'($urandom);
            @(posedge clk);
        end
        cfg_we  <= 1'b0;
        cur_cfg = setting;
    endtask

    function automatic int pick_temp();
        int sel;
        int base;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            case ($urandom_range(0, 3))
                0: base = int'(cur_cfg.warn_threshold);
                1: base = int'(cur_cfg.derate_threshold);
                2: base = int'(cur_cfg.stop_threshold);
                default: base = int'(cur_cfg.recover_threshold);
            endcase
            return base + int'($urandom_range(0, 4)) - 2;
        end
        if (sel < 75)
            return int'($urandom_range(0, 1048)) - 49;
        if (sel < 85) begin
            if ($urandom_range(0, 1))
                return 1000 + int'($urandom_range(0, 3));
            return -50 - int'($urandom_range(0, 3));
        end
        if (sel < 95)
            return int'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? 999 : -49;
    endfunction

    // Step a channel's clock mostly around the hold time
    function automatic logic [31:0] advance_clock(input int ch);
        logic [31:0] hold;
        int          sel;
        hold = {16'd0, cur_cfg.confirm_ms};
        sel  = $urandom_range(0, 99);
        if (sel < 40)
            clock_track[ch] += $urandom_range(0, int'(hold / 2));
        else if (sel < 70)
            clock_track[ch] += hold + $urandom_range(0, 3) - 1;
        else if (sel < 85)
            clock_track[ch] += hold + $urandom_range(1, 100000);
        else if (sel < 90)
            clock_track[ch] -= $urandom_range(1, 1000);
        else if (sel < 95)
            clock_track[ch] = $urandom;
        return clock_track[ch];
    endfunction

    task automatic random_phase(input int count);
        int ch;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                drain_results();
            if ($urandom_range(0, 9) == 0)
                ch = $urandom_range(0, 15);
            else
                ch = $urandom_range(0, NUM_CHANNELS - 1);
            send_sample(ch, pick_temp(), advance_clock(ch));
        end
        drain_results();
    endtask

    function automatic otg_pkg::t_cfg make_setting(input int w, input int d, input int s,
                                                   input int r, input int c);
        otg_pkg::t_cfg setting;
        setting.warn_threshold    = 16'(w);
        setting.derate_threshold  = 16'(d);
        setting.stop_threshold    = 16'(s);
        setting.recover_threshold = 16'(r);
        setting.confirm_ms        = 16'(c);
        return setting;
    endfunction

    initial begin
        cur_cfg = make_setting(int'(otg_pkg::WARN_RESET), int'(otg_pkg::DERATE_RESET),
                               int'(otg_pkg::STOP_RESET), int'(otg_pkg::RECOVER_RESET),
                               int'(otg_pkg::CONFIRM_RESET));
        for (int i = 0; i < 16; i++)
            clock_track[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Climb through every level on channel 0, then step back down
        send_sample(0, 86, 100);
        send_sample(0, 90, 5100);
        send_sample(0, 90, 5101);
        send_sample(0, 96, 5102);
        send_sample(0, 100, 10103);
        send_sample(0, 106, 10104);
        send_sample(0, 200, 15105);
        send_sample(0, 95, 20106);
        send_sample(0, 85, 25107);
        send_sample(0, 75, 30108);
        // Timestamp running backwards and wrapping
        send_sample(1, 90, 1000);
        send_sample(1, 90, 500);
        send_sample(1, 90, 32'hFFFF_FFF0);
        send_sample(1, 90, 32'h0000_2000);
        // Range limits and bad channels
        send_sample(0, 999, 30109);
        send_sample(0, -49, 30110);
        send_sample(0, 1000, 30111);
        send_sample(0, -50, 30112);
        send_sample(1, 32767, 32'hFFFF_FFFF);
        send_sample(1, -32768, 0);
        send_sample(2, 50, 0);
        send_sample(15, 50, 32'hFFFF_FFFF);
        send_sample(1, 0, 32'hFFFF_FFFF);
        drain_results();

        random_phase(PHASE_SAMPLES);

        load_setting(make_setting(85, 95, 105, 75, 20));
        steady_flow = 1'b1;
        random_phase(PHASE_SAMPLES);
        steady_flow = 1'b0;

        load_setting(make_setting(0, 0, 0, 0, 0));
        random_phase(PHASE_SAMPLES);

        load_setting(make_setting(65535, 65535, 65535, 65535, 65535));
        random_phase(PHASE_SAMPLES / 2);

        load_setting(make_setting($urandom_range(0, 1100), $urandom_range(0, 1100),
                                  $urandom_range(0, 1100), $urandom_range(0, 1100),
                                  $urandom_range(0, 300)));
        random_phase(PHASE_SAMPLES);

        load_setting(make_setting(300, 500, 700, 200, 1));
        random_phase(PHASE_SAMPLES);

        load_setting(make_setting(int'(otg_pkg::WARN_RESET), int'(otg_pkg::DERATE_RESET),
                                  int'(otg_pkg::STOP_RESET), int'(otg_pkg::RECOVER_RESET),
                                  int'(otg_pkg::CONFIRM_RESET)));
        random_phase(PHASE_SAMPLES / 2);

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
src/otg_pkg.sv
src/otg_cfg_regs.sv
src/otg_level_logic.sv
src/multi_level_overtemp_guard.sv
tb/otg_result_checker.sv
tb/tb_multi_level_overtemp_guard.sv
